### src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// root kind codes and the sideband word carried by each pipeline cell
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int OUT_WIDTH = 34;

   localparam logic [1:0] KIND_REAL       = 2'd0;
   localparam logic [1:0] KIND_COMPLEX    = 2'd1;
   localparam logic [1:0] KIND_DEGENERATE = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       a_neg;
   } side_type;

endpackage

### src/quadratic_root_solver_core.sv
// registered path from start to rsp_valid: stage 1, stage 2, the square root chain,
//    stage 3, the divider chain and the output register
// throughput: one request per cycle, busy is tied low; results cannot stall
// reset: synchronous active high, clears the valid bit of every stage
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: roots of a*x^2 + b*x + c in fixed point
// exact discriminant, then a chain of square root cells and a chain of
// divider cells, each cell retiring one bit per cycle
// ----------------------------------------------------------------------------
module quadratic_root_solver_core #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COEF_WIDTH-1:0]         req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]         req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]         req_coef_c,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_root_kind,
   output logic signed [qrs_pkg::OUT_WIDTH-1:0] rsp_first_value,
   output logic signed [qrs_pkg::OUT_WIDTH-1:0] rsp_second_value
);

   localparam int CW = COEF_WIDTH;
   localparam int F = FRAC_BITS;
   // |d| < 2^(2CW+1); radicand |d|*2^2F, padded to an even width
   localparam int DW = 2 * CW + 1;
   localparam int ROOT_W = CW + 1 + F;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int MAG_W = 2 * CW;      // |a|*|c|, |b|^2
   localparam int NUM_W = CW + F + 1;  // numerator magnitudes
   localparam int DEN_W = CW + 2;      // 2|a|
   localparam int SW = $bits(qrs_pkg::side_type);
   localparam int OW = qrs_pkg::OUT_WIDTH;
   localparam int PASS_S = SW + 2 + CW; // side, b positive, |b|

   assign busy = 1'b0;

   // ---- stage 1: magnitudes and products
   qrs_pkg::side_type s1_ff, s2_ff, s3_ff;
   logic [CW:0]     bm1_ff;
   logic            bpos1_ff, dsub1_ff;
   logic [MAG_W-1:0] bb1_ff, ac1_ff;
   logic [CW:0]     am_in, bm_in, cm_in;

   always_comb begin
      am_in = req_coef_a[CW-1] ? (CW+1)'(-{1'b1, req_coef_a}) : {1'b0, req_coef_a};
      bm_in = req_coef_b[CW-1] ? (CW+1)'(-{1'b1, req_coef_b}) : {1'b0, req_coef_b};
      cm_in = req_coef_c[CW-1] ? (CW+1)'(-{1'b1, req_coef_c}) : {1'b0, req_coef_c};
   end

   logic [CW:0] am1_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else       s1_ff.valid <= start;
      s1_ff.kind  <= (req_coef_a == '0) ? qrs_pkg::KIND_DEGENERATE : qrs_pkg::KIND_REAL;
      s1_ff.a_neg <= req_coef_a[CW-1];
      bpos1_ff    <= !req_coef_b[CW-1] && (req_coef_b != '0);
      bm1_ff      <= bm_in;
      am1_ff      <= am_in;
      // subtract when a and c share sign and c is nonzero
      dsub1_ff    <= (req_coef_a[CW-1] == req_coef_c[CW-1]) && (req_coef_c != '0);
      bb1_ff      <= MAG_W'(bm_in * bm_in);
      ac1_ff      <= MAG_W'(am_in * cm_in);
   end

   // ---- stage 2: discriminant sign and magnitude
   logic [DW:0]   bbx, acx;
   logic [DW-1:0] d2_ff;
   logic [CW:0]   bm2_ff;
   logic          bpos2_ff;
   logic [CW:0]   am2_ff;

   assign bbx = (DW+1)'(bb1_ff);
   assign acx = {ac1_ff, 2'b00} >> 0;

   always_ff @(posedge clock) begin
      if (reset) s2_ff.valid <= 1'b0;
      else       s2_ff.valid <= s1_ff.valid;
      s2_ff.a_neg <= s1_ff.a_neg;
      s2_ff.kind  <= s1_ff.kind;
      if (!dsub1_ff) begin
         d2_ff <= DW'(bbx + acx);
      end else if (bbx >= acx) begin
         d2_ff <= DW'(bbx - acx);
      end else begin
         d2_ff <= DW'(acx - bbx);
         if (s1_ff.kind != qrs_pkg::KIND_DEGENERATE) s2_ff.kind <= qrs_pkg::KIND_COMPLEX;
      end
      bm2_ff   <= bm1_ff;
      bpos2_ff <= bpos1_ff;
      am2_ff   <= am1_ff;
   end

   // ---- square root chain: ROOT_W cells
   logic [RAD_W-1:0]      rad_c  [ROOT_W+1];
   logic [ROOT_W+1:0]     rem_c  [ROOT_W+1];
   logic [ROOT_W-1:0]     root_c [ROOT_W+1];
   logic [PASS_S+CW:0]    pas_c  [ROOT_W+1];
   qrs_pkg::side_type     sq_side;
   logic                  sq_valid;

   assign rad_c[0]  = RAD_W'({d2_ff, {(2*F){1'b0}}});
   assign rem_c[0]  = '0;
   assign root_c[0] = '0;
   assign pas_c[0]  = {s2_ff, bpos2_ff, bm2_ff, am2_ff};

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      qrs_sqrt_cell #(
         .RAD_WIDTH(RAD_W), .ROOT_WIDTH(ROOT_W), .PASS_WIDTH(PASS_S + CW + 1)
      ) u_cell (
         .clock(clock), .rad_in(rad_c[g]), .rem_in(rem_c[g]), .root_in(root_c[g]),
         .pass_in(pas_c[g]), .rad_out(rad_c[g+1]), .rem_out(rem_c[g+1]),
         .root_out(root_c[g+1]), .pass_out(pas_c[g+1])
      );
   end

   // valid bits of the sqrt chain, kept resettable
   logic [ROOT_W-1:0] sqv_ff;
   always_ff @(posedge clock) begin
      if (reset) sqv_ff <= '0;
      else       sqv_ff <= {sqv_ff[ROOT_W-2:0], s2_ff.valid};
   end
   assign sq_side  = pas_c[ROOT_W][PASS_S+CW -: SW];
   assign sq_valid = sqv_ff[ROOT_W-1];

   // ---- stage 3: numerators
   logic [ROOT_W-1:0] sroot;
   logic [CW:0]       bmq;
   logic              bposq;
   logic [CW:0]       amq;
   logic [NUM_W:0]    bsc, sx;
   logic [NUM_W-1:0]  n1_ff, n2_ff;
   logic              n1neg_ff, n2neg_ff;
   logic [DEN_W-1:0]  den3_ff;

   assign sroot = root_c[ROOT_W];
   assign bposq = pas_c[ROOT_W][2*CW+2];
   assign bmq   = pas_c[ROOT_W][2*CW+1:CW+1];
   assign amq   = pas_c[ROOT_W][CW:0];
   assign bsc   = (NUM_W+1)'({bmq, {F{1'b0}}});
   assign sx    = (NUM_W+1)'(sroot);

   always_ff @(posedge clock) begin
      if (reset) s3_ff.valid <= 1'b0;
      else       s3_ff.valid <= sq_valid;
      s3_ff.kind  <= sq_side.kind;
      s3_ff.a_neg <= sq_side.a_neg;
      den3_ff     <= DEN_W'({amq, 1'b0});
      if (sq_side.kind == qrs_pkg::KIND_COMPLEX) begin
         // real part sign from b, imaginary part is s over |2a|
         n1_ff    <= NUM_W'(bsc);
         n1neg_ff <= bposq;
         n2_ff    <= NUM_W'(sx);
         n2neg_ff <= 1'b0;
      end else begin
         if (!bposq) begin
            n1_ff <= NUM_W'(bsc + sx); n1neg_ff <= 1'b0;
         end else if (sx >= bsc) begin
            n1_ff <= NUM_W'(sx - bsc); n1neg_ff <= 1'b0;
         end else begin
            n1_ff <= NUM_W'(bsc - sx); n1neg_ff <= 1'b1;
         end
         if (bposq) begin
            n2_ff <= NUM_W'(bsc + sx); n2neg_ff <= 1'b1;
         end else if (bsc >= sx) begin
            n2_ff <= NUM_W'(bsc - sx); n2neg_ff <= 1'b0;
         end else begin
            n2_ff <= NUM_W'(sx - bsc); n2neg_ff <= 1'b1;
         end
      end
   end

   // ---- divider chain: NUM_W cells
   localparam int PASS_D = SW + 2;
   logic [DEN_W-1:0]  dd_c [NUM_W+1];
   logic [NUM_W-1:0]  q1_c [NUM_W+1];
   logic [NUM_W-1:0]  q2_c [NUM_W+1];
   logic [DEN_W:0]    r1_c [NUM_W+1];
   logic [DEN_W:0]    r2_c [NUM_W+1];
   logic [PASS_D-1:0] pd_c [NUM_W+1];

   assign dd_c[0] = den3_ff;
   assign q1_c[0] = n1_ff;
   assign q2_c[0] = n2_ff;
   assign r1_c[0] = '0;
   assign r2_c[0] = '0;
   assign pd_c[0] = {s3_ff, n1neg_ff, n2neg_ff};

   for (genvar g = 0; g < NUM_W; g++) begin : g_div
      qrs_div_cell #(
         .NUM_WIDTH(NUM_W), .DEN_WIDTH(DEN_W), .PASS_WIDTH(PASS_D)
      ) u_cell (
         .clock(clock), .den_in(dd_c[g]), .num1_in(q1_c[g]), .rem1_in(r1_c[g]),
         .num2_in(q2_c[g]), .rem2_in(r2_c[g]), .pass_in(pd_c[g]),
         .den_out(dd_c[g+1]), .num1_out(q1_c[g+1]), .rem1_out(r1_c[g+1]),
         .num2_out(q2_c[g+1]), .rem2_out(r2_c[g+1]), .pass_out(pd_c[g+1])
      );
   end

   logic [NUM_W-1:0] dv_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else       dv_ff <= {dv_ff[NUM_W-2:0], s3_ff.valid};
   end

   // ---- output stage: sign, saturation, degenerate zeros
   qrs_pkg::side_type ds;
   logic              q1neg, q2neg;
   logic [OW-1:0]     v1, v2;

   assign ds = pd_c[NUM_W][PASS_D-1 -: SW];

   function automatic logic [OW-1:0] pack_out(input logic neg, input logic [NUM_W-1:0] mag);
      logic [NUM_W+1:0] m;
      logic [NUM_W+1:0] lim;
      begin
         m   = (NUM_W+2)'(mag);
         lim = (NUM_W+2)'(1) << (OW - 1);
         if (neg) begin
            if (m > lim) m = lim;
            pack_out = OW'(-m);
         end else begin
            if (m > lim - 1) m = lim - 1;
            pack_out = OW'(m);
         end
      end
   endfunction

   always_comb begin
      q1neg = (q1_c[NUM_W] != '0) && (pd_c[NUM_W][1] != ds.a_neg);
      q2neg = (ds.kind != qrs_pkg::KIND_COMPLEX) && (q2_c[NUM_W] != '0)
              && (pd_c[NUM_W][0] != ds.a_neg);
      v1 = pack_out(q1neg, q1_c[NUM_W]);
      v2 = pack_out(q2neg, q2_c[NUM_W]);
   end

   logic          ov_ff;
   logic [1:0]    okind_ff;
   logic [OW-1:0] o1_ff, o2_ff;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= dv_ff[NUM_W-1];
      okind_ff <= ds.kind;
      if (ds.kind == qrs_pkg::KIND_DEGENERATE) begin
         o1_ff <= '0;
         o2_ff <= '0;
      end else begin
         o1_ff <= v1;
         o2_ff <= v2;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_root_kind    = okind_ff;
   assign rsp_first_value  = o1_ff;
   assign rsp_second_value = o2_ff;

endmodule

### src/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one stage of the restoring square root
// decides one root bit from two radicand bits per cycle
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
   parameter int RAD_WIDTH = 96,
   parameter int ROOT_WIDTH = 48,
   parameter int PASS_WIDTH = 64
) (
   input  logic                  clock,
   input  logic [RAD_WIDTH-1:0]  rad_in,
   input  logic [ROOT_WIDTH+1:0] rem_in,
   input  logic [ROOT_WIDTH-1:0] root_in,
   input  logic [PASS_WIDTH-1:0] pass_in,
   output logic [RAD_WIDTH-1:0]  rad_out,
   output logic [ROOT_WIDTH+1:0] rem_out,
   output logic [ROOT_WIDTH-1:0] root_out,
   output logic [PASS_WIDTH-1:0] pass_out
);

   logic [ROOT_WIDTH+1:0] trial;
   logic [ROOT_WIDTH+1:0] cand;
   logic [RAD_WIDTH-1:0]  rad_ff;
   logic [ROOT_WIDTH+1:0] rem_ff;
   logic [ROOT_WIDTH-1:0] root_ff;
   logic [PASS_WIDTH-1:0] pass_ff;

   // shift in the next two radicand bits, try root*4+1
   assign trial = {rem_in[ROOT_WIDTH-1:0], rad_in[RAD_WIDTH-1 -: 2]};
   assign cand  = {root_in, 2'b01};

   always_ff @(posedge clock) begin
      rad_ff  <= {rad_in[RAD_WIDTH-3:0], 2'b00};
      pass_ff <= pass_in;
      if (trial >= cand) begin
         rem_ff  <= trial - cand;
         root_ff <= {root_in[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         rem_ff  <= trial;
         root_ff <= {root_in[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign pass_out = pass_ff;

endmodule

### src/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one stage of a restoring divider lane pair
// produces one quotient bit for each of two numerators sharing a divisor
// ----------------------------------------------------------------------------
module qrs_div_cell #(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 33,
   parameter int PASS_WIDTH = 8
) (
   input  logic                  clock,
   input  logic [DEN_WIDTH-1:0]  den_in,
   input  logic [NUM_WIDTH-1:0]  num1_in,
   input  logic [DEN_WIDTH:0]    rem1_in,
   input  logic [NUM_WIDTH-1:0]  num2_in,
   input  logic [DEN_WIDTH:0]    rem2_in,
   input  logic [PASS_WIDTH-1:0] pass_in,
   output logic [DEN_WIDTH-1:0]  den_out,
   output logic [NUM_WIDTH-1:0]  num1_out,
   output logic [DEN_WIDTH:0]    rem1_out,
   output logic [NUM_WIDTH-1:0]  num2_out,
   output logic [DEN_WIDTH:0]    rem2_out,
   output logic [PASS_WIDTH-1:0] pass_out
);

   // numerator register shifts left: msb feeds the remainder, quotient bit enters lsb
   logic [DEN_WIDTH:0]    t1, t2;
   logic [DEN_WIDTH-1:0]  den_ff;
   logic [NUM_WIDTH-1:0]  num1_ff, num2_ff;
   logic [DEN_WIDTH:0]    rem1_ff, rem2_ff;
   logic [PASS_WIDTH-1:0] pass_ff;

   assign t1 = {rem1_in[DEN_WIDTH-1:0], num1_in[NUM_WIDTH-1]};
   assign t2 = {rem2_in[DEN_WIDTH-1:0], num2_in[NUM_WIDTH-1]};

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      pass_ff <= pass_in;
      if (t1 >= {1'b0, den_in}) begin
         rem1_ff <= t1 - {1'b0, den_in};
         num1_ff <= {num1_in[NUM_WIDTH-2:0], 1'b1};
      end else begin
         rem1_ff <= t1;
         num1_ff <= {num1_in[NUM_WIDTH-2:0], 1'b0};
      end
      if (t2 >= {1'b0, den_in}) begin
         rem2_ff <= t2 - {1'b0, den_in};
         num2_ff <= {num2_in[NUM_WIDTH-2:0], 1'b1};
      end else begin
         rem2_ff <= t2;
         num2_ff <= {num2_in[NUM_WIDTH-2:0], 1'b0};
      end
   end

   assign den_out  = den_ff;
   assign num1_out = num1_ff;
   assign rem1_out = rem1_ff;
   assign num2_out = num2_ff;
   assign rem2_out = rem2_ff;
   assign pass_out = pass_ff;

endmodule

### tb/quadratic_root_solver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_checker: root prediction and response check
// watches accepted requests, predicts kind and both fixed point values,
// and compares every response in order against the predicted roots
// ----------------------------------------------------------------------------
module quadratic_root_solver_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] coef_a,
   input  logic signed [15:0] coef_b,
   input  logic signed [15:0] coef_c,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_root_kind,
   input  logic signed [33:0] rsp_first_value,
   input  logic signed [33:0] rsp_second_value,
   output int                 fail_count,
   output int                 roots_pending,
   output int                 real_seen,
   output int                 complex_seen,
   output int                 degenerate_seen
);

   localparam int FRAC = 16;

   typedef struct {
      logic [1:0]         kind;
      logic signed [33:0] first;
      logic signed [33:0] second;
   } roots_type;

   roots_type roots_queue[$];

   function automatic logic [127:0] floor_sqrt(logic [127:0] x);
      logic [127:0] r;
      logic [127:0] cand;
      r = '0;
      for (int i = 40; i >= 0; i--) begin
         cand = r | (128'd1 << i);
         if (cand * cand <= x) r = cand;
      end
      return r;
   endfunction

   // truncated quotient clamped into the 34-bit signed range
   function automatic logic signed [33:0] clamp_out(logic signed [127:0] v);
      if (v > 128'sd8589934591) return 34'sh1_FFFF_FFFF;
      if (v < -128'sd8589934592) return 34'sh2_0000_0000;
      return v[33:0];
   endfunction

   function automatic roots_type solve_roots(logic signed [15:0] a,
                                             logic signed [15:0] b,
                                             logic signed [15:0] c);
      roots_type res;
      logic signed [127:0] av, bv, cv, disc, bscaled, den, s;
      logic [127:0] dmag;
      av = a;
      bv = b;
      cv = c;
      if (a == 0) begin
         res.kind = qrs_pkg::KIND_DEGENERATE;
         res.first = '0;
         res.second = '0;
         return res;
      end
      disc = bv * bv - 4 * av * cv;
      dmag = (disc < 0) ? -disc : disc;
      s = $signed(floor_sqrt(dmag << (2 * FRAC)));
      bscaled = bv <<< FRAC;
      den = 2 * av;
      if (disc >= 0) begin
         res.kind = qrs_pkg::KIND_REAL;
         res.first = clamp_out((-bscaled + s) / den);
         res.second = clamp_out((-bscaled - s) / den);
      end else begin
         res.kind = qrs_pkg::KIND_COMPLEX;
         res.first = clamp_out(-bscaled / den);
         res.second = clamp_out(s / ((den < 0) ? -den : den));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      roots_type want;
      if (reset) begin
         fail_count = 0;
         real_seen = 0;
         complex_seen = 0;
         degenerate_seen = 0;
         roots_pending <= 0;
      end else begin
         if (start && !busy) roots_queue.push_back(solve_roots(coef_a, coef_b, coef_c));
         if (rsp_valid) begin
            if (roots_queue.size() == 0) begin
               $display("%0t: unexpected response kind %0d first %0d second %0d",
                        $time, rsp_root_kind, rsp_first_value, rsp_second_value);
               fail_count++;
            end else begin
               want = roots_queue.pop_front();
               if (rsp_root_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                           rsp_root_kind);
                  fail_count++;
               end
               if (rsp_first_value !== want.first) begin
                  $display("%0t: first value expected %0d actual %0d", $time,
                           want.first, rsp_first_value);
                  fail_count++;
               end
               if (rsp_second_value !== want.second) begin
                  $display("%0t: second value expected %0d actual %0d", $time,
                           want.second, rsp_second_value);
                  fail_count++;
               end
               case (want.kind)
                  qrs_pkg::KIND_REAL: real_seen++;
                  qrs_pkg::KIND_COMPLEX: complex_seen++;
                  default: degenerate_seen++;
               endcase
            end
         end
         roots_pending <= roots_queue.size();
      end
   end

endmodule

### tb/quadratic_root_solver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb: top of the root solver testbench
// drives directed and random coefficient sets in bursts with gaps;
// the checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;

   localparam int RANDOM_REQUESTS = 800;
   localparam int DRAIN_CYCLES = 100;       // longer than the pipeline from start to rsp_valid
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_coef_a;
   logic signed [15:0] req_coef_b;
   logic signed [15:0] req_coef_c;
   logic               rsp_valid;
   logic [1:0]         rsp_root_kind;
   logic signed [33:0] rsp_first_value;
   logic signed [33:0] rsp_second_value;
   int                 fail_count;
   int                 roots_pending;
   int                 real_seen;
   int                 complex_seen;
   int                 degenerate_seen;
   int                 cycle_count;
   int                 burst_left;

   quadratic_root_solver_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_coef_a(req_coef_a),
      .req_coef_b(req_coef_b),
      .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid),
      .rsp_root_kind(rsp_root_kind),
      .rsp_first_value(rsp_first_value),
      .rsp_second_value(rsp_second_value)
   );

   quadratic_root_solver_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .coef_a(req_coef_a),
      .coef_b(req_coef_b),
      .coef_c(req_coef_c),
      .rsp_valid(rsp_valid),
      .rsp_root_kind(rsp_root_kind),
      .rsp_first_value(rsp_first_value),
      .rsp_second_value(rsp_second_value),
      .fail_count(fail_count),
      .roots_pending(roots_pending),
      .real_seen(real_seen),
      .complex_seen(complex_seen),
      .degenerate_seen(degenerate_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, far above the slowest correct run
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // one request; start stays high while a burst lasts, and each burst is
   // preceded by a random gap with start low, which may be empty
   task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
                               logic signed [15:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // occasionally long bursts so the pipeline fills completely
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // coefficient drawn from full range, small values or the extremes
   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom());
         2, 3: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
         4: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
         default: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
      endcase
   endfunction

   initial begin
      logic signed [15:0] a, b, c;
      int r1, r2, sel;
      reset = 1'b1;
      start = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, double root, both discriminant signs, extremes
      send_request(16'sd0, 16'sd5, 16'sd7);
      send_request(16'sd0, 16'sh8000, 16'sh7fff);
      send_request(16'sd1, -16'sd2, 16'sd1);          // double root at one
      send_request(16'sd1, 16'sd0, -16'sd4);
      send_request(16'sd1, 16'sd0, 16'sd4);           // purely imaginary pair
      send_request(-16'sd1, 16'sd3, 16'sd0);          // c zero
      send_request(16'sd2, 16'sd3, 16'sd5);
      send_request(-16'sd3, -16'sd1, -16'sd7);
      send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_request(16'sh8000, 16'sh8000, 16'sh8000);
      send_request(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_request(16'sh7fff, 16'sh8000, 16'sh8000);
      send_request(16'sd1, 16'sh8000, 16'sh7fff);     // widest real roots
      send_request(16'sd1, 16'sd0, 16'sh8000);
      send_request(-16'sd1, 16'sd0, 16'sh8000);       // largest complex root
      send_request(16'sd1, 16'sd1, 16'sd0);
      send_request(16'sd1, 16'sd0, 16'sd0);
      send_request(16'sh8000, 16'sd0, 16'sd0);
      send_request(-16'sd1, -16'sd1, -16'sd1);
      send_request(16'sd3, -16'sd7, 16'sd2);
      send_request(16'shffff, 16'sh5555, 16'shaaaa);

      // random: mostly free coefficients, some built from integer roots
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) begin
            r1 = $urandom_range(0, 30);
            r2 = $urandom_range(0, 30);
            a = $signed(16'($urandom_range(0, 20))) - 16'sd10;
            b = -a * 16'(r1 + r2 - 30);
            c = a * 16'((r1 - 15) * (r2 - 15));
         end else if (sel == 2) begin
            a = 16'sd0;
            b = pick_coef();
            c = pick_coef();
         end else begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
         end
         send_request(a, b, c);
      end
      start <= 1'b0;

      // drain the pipeline then give stray responses a chance to show
      while (roots_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d real, %0d complex and %0d degenerate responses",
               real_seen, complex_seen, degenerate_seen);
      $display("requests sent in bursts with random gaps over %0d cycles", cycle_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
